/* rtl/npr_pkg.sv */
// npr_pkg: shared types and constants of the nearest point ranker
// payload structs, register indexes, op codes and fixed datapath widths
// no dependencies
`default_nettype none

package npr_pkg;

  // fixed field widths
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 2;
  localparam int SLOT_W   = 5;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;

  // op codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDENT_LIMIT = 2'd1;

  typedef struct packed {
    logic                      op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } npr_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] point_index;
    logic [SLOT_W-1:0] rank;
    logic              resident;
    logic              last;
  } npr_result_t;

  // one stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } npr_point_t;

endpackage

`default_nettype wire

/* rtl/npr_dist_unit.sv */
// npr_dist_unit: point memory and squared distance pipeline
// streams one squared distance per slot in slot order after a query start
// depends on npr_pkg
`default_nettype none

module npr_dist_unit
  import npr_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire npr_item_t                            item,
  input  wire logic                                 load_en,
  input  wire logic                                 start,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]      count,
  output logic                                      d_valid,
  output logic [$clog2(MAX_POINTS)-1:0]             d_idx,
  output logic [DIST_W-1:0]                         d_dist,
  output logic                                      d_last
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  npr_point_t point_mem [MAX_POINTS];

  // issue sequencer
  logic             issuing;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] left;
  npr_point_t       query;

  // stage registers
  logic             v0, v1, v2;
  logic             last0, last1, last2;
  logic [IDX_W-1:0] idx0, idx1, idx2;
  npr_point_t       rdata;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;

  logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;

  // point memory: load port and sequential read port
  always_ff @(posedge clk) begin
    if (load_en && (int'(item.slot) < MAX_POINTS)) begin
      point_mem[IDX_W'(item.slot)] <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
    end
    if (issuing) begin
      rdata <= point_mem[rd_addr];
    end
  end

  // issue one read per cycle over the slots in use
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v0      <= 1'b0;
    end else begin
      v0 <= issuing;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && left == CNT_W'(1)) begin
        issuing <= 1'b0;
      end
    end
    if (start) begin
      rd_addr <= '0;
      left    <= count;
      query   <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
    end else if (issuing) begin
      rd_addr <= rd_addr + IDX_W'(1);
      left    <= left - CNT_W'(1);
    end
    idx0  <= rd_addr;
    last0 <= (left == CNT_W'(1));
  end

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign prod_z = dz * dz;

  // differences, squares, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      v1      <= v0;
      v2      <= v1;
      d_valid <= v2;
    end
    dx <= {query.x[COORD_W-1], query.x} - {rdata.x[COORD_W-1], rdata.x};
    dy <= {query.y[COORD_W-1], query.y} - {rdata.y[COORD_W-1], rdata.y};
    dz <= {query.z[COORD_W-1], query.z} - {rdata.z[COORD_W-1], rdata.z};
    idx1  <= idx0;
    last1 <= last0;

    sq_x  <= prod_x[SQ_W-1:0];
    sq_y  <= prod_y[SQ_W-1:0];
    sq_z  <= prod_z[SQ_W-1:0];
    idx2  <= idx1;
    last2 <= last1;

    d_dist <= {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    d_idx  <= idx2;
    d_last <= last2;
  end

endmodule

`default_nettype wire

/* rtl/npr_rank_cell.sv */
// npr_rank_cell: one cell of the ranking chain
// keeps its own slot's distance and rank count, forwards later distances
// depends on npr_pkg
`default_nettype none

module npr_rank_cell
  import npr_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [$clog2(MAX_POINTS)-1:0] in_idx,
  input  wire logic [DIST_W-1:0]             in_dist,
  input  wire logic [$clog2(MAX_POINTS)-1:0] in_rank,
  output logic                               out_valid,
  output logic [$clog2(MAX_POINTS)-1:0]      out_idx,
  output logic [DIST_W-1:0]                  out_dist,
  output logic [$clog2(MAX_POINTS)-1:0]      out_rank,
  input  wire logic                          shift,
  input  wire logic [$clog2(MAX_POINTS)-1:0] next_rank,
  output logic [$clog2(MAX_POINTS)-1:0]      rank
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [DIST_W-1:0] own_dist;
  logic              mine;
  logic              own_wins;   // own slot counts toward the passing one
  logic              pass_wins;  // passing slot counts toward own

  assign mine      = in_idx == IDX_W'(CELL_IDX);
  // own slot index is lower, so a tie favors own
  assign own_wins  = own_dist <= in_dist;
  assign pass_wins = in_dist < own_dist;

  // forward distances of higher slots
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid && !mine;
    end
    out_idx  <= in_idx;
    out_dist <= in_dist;
    out_rank <= in_rank + IDX_W'(own_wins);
  end

  // own distance and rank, shifted toward the head during drain
  always_ff @(posedge clk) begin
    if (shift) begin
      rank <= next_rank;
    end else if (in_valid && mine) begin
      own_dist <= in_dist;
      rank     <= in_rank;
    end else if (in_valid) begin
      rank <= rank + IDX_W'(pass_wins);
    end
  end

endmodule

`default_nettype wire

/* rtl/nearest_point_ranker_top.sv */
// nearest_point_ranker_top: ranks stored 3-D points by squared distance to a query
// control, configuration registers, result register and the chain of rank cells
// depends on npr_pkg, npr_dist_unit, npr_rank_cell
//
// Usage: items arrive on item_valid/item_ready. A load (op = load) writes one
// point into a slot; slots at or above MAX_POINTS are
// dropped. A query (op = query) makes n results, n being point_count clamped
// to 1..MAX_POINTS, in slot order on result_valid/result_ready; the final one
// has last set. Configuration writes on cfg_valid/cfg_ready are always taken.
// Timing: a query's squared distances leave a four stage pipeline (memory
// read, difference, one multiplier per axis, sum) one slot per cycle and
// walk down the cell chain, one cell per cycle; once the ranks have settled,
// results leave one per cycle while the receiver is ready. item_ready is
// high only while no query is in flight.
// A stalled receiver holds the result register and freezes the drain.
// Reset empties the pipeline and result register, sets point_count to 1 and
// resident_limit to 0; stored points are undefined until loaded.
`default_nettype none

module nearest_point_ranker_top
  import npr_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire npr_item_t            item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output npr_result_t               result
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPUTE,
    S_SETTLE,
    S_DRAIN
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] point_count;
  logic [CFG_W-1:0] resident_limit;
  logic [CNT_W-1:0] n_reg;
  logic [IDX_W-1:0] wait_cnt;
  logic [CNT_W-1:0] drain_left;
  logic [IDX_W-1:0] drain_idx;

  logic             item_xfer;
  logic             load_en;
  logic             start;
  logic [CMP_W-1:0] pc_ext;
  logic [CMP_W-1:0] n_next;
  logic             emit;

  logic                d_valid;
  logic [IDX_W-1:0]    d_idx;
  logic [DIST_W-1:0]   d_dist;
  logic                d_last;

  // chain wiring: entry k feeds cell k
  logic                chain_valid [MAX_POINTS];
  logic [IDX_W-1:0]    chain_idx   [MAX_POINTS];
  logic [DIST_W-1:0]   chain_dist  [MAX_POINTS];
  logic [IDX_W-1:0]    chain_rank  [MAX_POINTS];
  logic [IDX_W-1:0]    rank_tap    [MAX_POINTS+1];

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign load_en    = item_xfer && (item.op == OP_LOAD);
  assign start      = item_xfer && (item.op == OP_QUERY);

  // clamp the point count to 1..MAX_POINTS
  assign pc_ext = CMP_W'(point_count);
  always_comb begin
    if (pc_ext == '0) begin
      n_next = CMP_W'(1);
    end else if (pc_ext > CMP_W'(MAX_POINTS)) begin
      n_next = CMP_W'(MAX_POINTS);
    end else begin
      n_next = pc_ext;
    end
  end

  // one result per cycle while the result register is free
  assign emit = (state == S_DRAIN) && (drain_left != '0) && (!result_valid || result_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= CFG_W'(1);
      resident_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POINT_COUNT:    point_count    <= cfg_data;
        REG_RESIDENT_LIMIT: resident_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  npr_dist_unit #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .load_en (load_en),
    .start   (start),
    .count   (CNT_W'(n_next)),
    .d_valid (d_valid),
    .d_idx   (d_idx),
    .d_dist  (d_dist),
    .d_last  (d_last)
  );

  // head of the chain takes the distance stream
  assign chain_valid[0]       = d_valid;
  assign chain_idx[0]         = d_idx;
  assign chain_dist[0]        = d_dist;
  assign chain_rank[0]        = '0;
  assign rank_tap[MAX_POINTS] = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    if (k < MAX_POINTS - 1) begin : g_mid
      npr_rank_cell #(
        .MAX_POINTS(MAX_POINTS),
        .CELL_IDX  (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (chain_valid[k]),
        .in_idx    (chain_idx[k]),
        .in_dist   (chain_dist[k]),
        .in_rank   (chain_rank[k]),
        .out_valid (chain_valid[k+1]),
        .out_idx   (chain_idx[k+1]),
        .out_dist  (chain_dist[k+1]),
        .out_rank  (chain_rank[k+1]),
        .shift     (emit),
        .next_rank (rank_tap[k+1]),
        .rank      (rank_tap[k])
      );
    end else begin : g_end
      npr_rank_cell #(
        .MAX_POINTS(MAX_POINTS),
        .CELL_IDX  (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (chain_valid[k]),
        .in_idx    (chain_idx[k]),
        .in_dist   (chain_dist[k]),
        .in_rank   (chain_rank[k]),
        .out_valid (),
        .out_idx   (),
        .out_dist  (),
        .out_rank  (),
        .shift     (emit),
        .next_rank (rank_tap[k+1]),
        .rank      (rank_tap[k])
      );
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_COMPUTE;
          end
        end
        S_COMPUTE: begin
          if (d_valid && d_last) begin
            state <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          if (wait_cnt == '0) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_left == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    if (start) begin
      n_reg <= CNT_W'(n_next);
    end
    // last distance still has n - 1 cells to walk
    if (state == S_COMPUTE) begin
      wait_cnt <= IDX_W'(n_reg - CNT_W'(1));
    end else if (state == S_SETTLE) begin
      wait_cnt <= wait_cnt - IDX_W'(1);
    end
    if (state == S_SETTLE) begin
      drain_left <= n_reg;
      drain_idx  <= '0;
    end else if (emit) begin
      drain_left <= drain_left - CNT_W'(1);
      drain_idx  <= drain_idx + IDX_W'(1);
    end
    if (emit) begin
      result.point_index <= SLOT_W'(drain_idx);
      result.rank        <= SLOT_W'(rank_tap[0]);
      result.resident    <= CMP_W'(rank_tap[0]) < CMP_W'(resident_limit);
      result.last        <= (drain_left == CNT_W'(1));
    end
  end

endmodule

`default_nettype wire
